@@ rtl/core/ssmd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssmd_pkg
// Types, command codes and glyph tables of the seven-segment display
// multiplexer.
// ----------------------------------------------------------------------------
package ssmd_pkg;

	// command codes, codes 11 to 15 are no-ops
	typedef enum logic [3:0] {
		ACT_TICK   = 4'd0,
		ACT_WRITE  = 4'd1,
		ACT_OR     = 4'd2,
		ACT_DIGIT  = 4'd3,
		ACT_DOT    = 4'd4,
		ACT_CHAR   = 4'd5,
		ACT_SCROLL = 4'd6,
		ACT_CLEAR  = 4'd7,
		ACT_PANIC  = 4'd8,
		ACT_READ   = 4'd9,
		ACT_LOOKUP = 4'd10
	} action_t;

	typedef struct packed {
		logic [3:0] action;
		logic [2:0] position;
		logic [7:0] value;
		logic       dot_flag;
	} cmd_t;

	typedef struct packed {
		logic [5:0] select_lines;
		logic [7:0] segment_lines;
		logic [7:0] read_data;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic exec;
	} ctrl_t;

	typedef enum logic {
		ST_EMPTY,
		ST_FULL
	} state_t;

	// segment bits: 0 mid, 1 top-left, 2 top, 3 top-right, 4 dot,
	// 5 bottom-right, 6 bottom, 7 bottom-left
	localparam logic [7:0] SEG_DOT  = 8'h10;
	localparam logic [7:0] SEG_BANG = 8'h38;
	localparam int PANIC_SLOTS = 8;

	localparam logic [7:0] DIGIT_GLYPH [10] = '{
		8'd238, 8'd40, 8'd205, 8'd109, 8'd43, 8'd103, 8'd231, 8'd44, 8'd239, 8'd111
	};

	localparam logic [7:0] LETTER_GLYPH [26] = '{
		8'd175, 8'd239, 8'd198, 8'd238, 8'd199, 8'd135, 8'd227, 8'd171, 8'd130,
		8'd40, 8'd35, 8'd194, 8'd174, 8'd174, 8'd238, 8'd143, 8'd47, 8'd175,
		8'd103, 8'd134, 8'd234, 8'd234, 8'd234, 8'd171, 8'd43, 8'd205
	};

	localparam logic [7:0] PANIC_PATTERN [PANIC_SLOTS] = '{
		8'd0, 8'd198, 8'd130, 8'd174, 8'd175, 8'd143, 8'd0, 8'd0
	};

	// ascii code to segment glyph, zero where there is no glyph
	function automatic logic [7:0] glyph_of(input logic [7:0] code);
		logic [7:0] glyph;
		logic [7:0] offs;
		glyph = 8'h00;
		offs  = 8'h00;
		if (code >= 8'h30 && code <= 8'h39) begin
			offs  = code - 8'h30;
			glyph = DIGIT_GLYPH[offs[3:0]];
		end else if (code >= 8'h61 && code <= 8'h7a) begin
			offs  = code - 8'h61;
			glyph = LETTER_GLYPH[offs[4:0]];
		end else if (code >= 8'h41 && code <= 8'h5a) begin
			offs  = code - 8'h41;
			glyph = LETTER_GLYPH[offs[4:0]];
		end else if (code == 8'h2e || code == 8'h2c) begin
			glyph = SEG_DOT;
		end else if (code == 8'h21) begin
			glyph = SEG_BANG;
		end
		return glyph;
	endfunction

endpackage

@@ rtl/core/ssmd_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssmd_ctrl
// Handshake controller: tracks the output register and tells the datapath
// when to execute a command.
// ----------------------------------------------------------------------------
module ssmd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output ssmd_pkg::ctrl_t ctrl
);
	import ssmd_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_EMPTY;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd_ready = 1'b0;
		rsp_valid = 1'b0;
		ctrl.exec = 1'b0;
		unique case (state_q)
			ST_EMPTY: begin
				cmd_ready = 1'b1;
				ctrl.exec = cmd_valid;
				if (cmd_valid) begin
					state_d = ST_FULL;
				end
			end
			ST_FULL: begin
				rsp_valid = 1'b1;
				// slot drains this cycle, so a new command may refill it
				cmd_ready = rsp_ready;
				ctrl.exec = cmd_valid && rsp_ready;
				if (rsp_ready && !cmd_valid) begin
					state_d = ST_EMPTY;
				end
			end
			default: begin
				state_d = ST_EMPTY;
			end
		endcase
	end

endmodule

@@ rtl/core/ssmd_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssmd_datapath
// Frame buffer, scan index, command execution and the output register.
// ----------------------------------------------------------------------------
module ssmd_datapath #(
	parameter int DIGITS = 6
) (
	input  logic            clk,
	input  logic            arst_n,
	input  ssmd_pkg::ctrl_t ctrl,
	input  ssmd_pkg::cmd_t  cmd,
	output ssmd_pkg::rsp_t  rsp
);
	import ssmd_pkg::*;

	localparam int IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
	localparam logic [3:0] DIGITS_N = 4'(DIGITS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIGITS - 1);
	localparam int SEL_W = 6;

	logic [7:0]       fb_q [DIGITS];
	logic [7:0]       fb_d [DIGITS];
	logic [IDX_W-1:0] scan_q;
	logic [IDX_W-1:0] scan_d;
	rsp_t             rsp_q;
	rsp_t             rsp_d;

	action_t          act;
	logic             pos_ok;
	logic [IDX_W-1:0] pos_idx;
	logic [IDX_W-1:0] rd_addr;
	logic [7:0]       rd_byte;

	assign act     = action_t'(cmd.action);
	assign pos_ok  = {1'b0, cmd.position} < DIGITS_N;
	assign pos_idx = IDX_W'(cmd.position);
	assign rd_addr = (act == ACT_TICK) ? scan_q : pos_idx;
	assign rd_byte = ({{(32-IDX_W){1'b0}}, rd_addr} < 32'(DIGITS)) ? fb_q[rd_addr] : 8'h00;

	always_comb begin
		fb_d   = fb_q;
		scan_d = scan_q;
		rsp_d  = '0;
		case (act)
			ACT_TICK: begin
				for (int i = 0; i < SEL_W; i++) begin
					rsp_d.select_lines[i] = (int'(scan_q) == i);
				end
				rsp_d.segment_lines = rd_byte;
				scan_d = (scan_q == LAST_IDX) ? '0 : scan_q + 1'b1;
			end
			ACT_WRITE: begin
				if (pos_ok) fb_d[pos_idx] = cmd.value;
			end
			ACT_OR: begin
				if (pos_ok) fb_d[pos_idx] = rd_byte | cmd.value;
			end
			ACT_DIGIT: begin
				if (pos_ok && cmd.value <= 8'd9) fb_d[pos_idx] = DIGIT_GLYPH[cmd.value[3:0]];
			end
			ACT_DOT: begin
				if (pos_ok) begin
					fb_d[pos_idx] = cmd.dot_flag ? (rd_byte | SEG_DOT) : (rd_byte & ~SEG_DOT);
				end
			end
			ACT_CHAR: begin
				if (pos_ok) begin
					fb_d[pos_idx] = glyph_of(cmd.value) | (cmd.dot_flag ? SEG_DOT : 8'h00);
				end
			end
			ACT_SCROLL: begin
				for (int i = DIGITS - 1; i > 0; i--) begin
					fb_d[i] = fb_q[i-1];
				end
				fb_d[0] = cmd.value;
			end
			ACT_CLEAR: begin
				for (int i = 0; i < DIGITS; i++) begin
					fb_d[i] = 8'h00;
				end
			end
			ACT_PANIC: begin
				for (int i = 0; i < DIGITS; i++) begin
					fb_d[i] = PANIC_PATTERN[i];
				end
			end
			ACT_READ: begin
				if (pos_ok) rsp_d.read_data = rd_byte;
			end
			ACT_LOOKUP: begin
				rsp_d.read_data = glyph_of(cmd.value);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIGITS; i++) begin
				fb_q[i] <= 8'h00;
			end
			scan_q <= '0;
		end else if (ctrl.exec) begin
			fb_q   <= fb_d;
			scan_q <= scan_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.exec) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp = rsp_q;

endmodule

@@ rtl/core/seven_segment_mux_display.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_mux_display
// Multiplexed seven-segment display driver with a DIGITS-byte frame buffer.
// ----------------------------------------------------------------------------
// Each command is executed in the cycle it is transferred and its single
// response sits in an output register from the next cycle on, so the block
// takes one command per clock as long as responses are taken; the rate is set
// by the one-entry output register, which a new command may refill in the same
// cycle the previous response is transferred. Commands update the frame
// buffer (write, or, digit glyph, dot, ascii glyph, scroll, clear, panic
// pattern) or read it back (buffer read, glyph lookup). A tick command returns
// the one-hot select and segment byte of the currently scanned digit and moves
// the scan to the next digit, wrapping after DIGITS-1. Positions at or beyond
// DIGITS are ignored and read as zero. Segment bits: 0 middle, 1 top-left,
// 2 top, 3 top-right, 4 dot, 5 bottom-right, 6 bottom, 7 bottom-left.
module seven_segment_mux_display #(
	parameter int DIGITS = 6
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  ssmd_pkg::cmd_t cmd,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output ssmd_pkg::rsp_t rsp
);
	import ssmd_pkg::*;

	// execute strobe from controller to datapath
	ctrl_t ctrl;

	// handshake and output slot tracking
	ssmd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.ctrl      (ctrl)
	);

	// frame buffer, scan index and response register
	ssmd_datapath #(
		.DIGITS (DIGITS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.cmd    (cmd),
		.rsp    (rsp)
	);

endmodule
